/* hw/rtl/hsv_to_rgb_brightness_limit_macros.svh */
// ---------------------------------------------------------------------------
// hsv to rgb brightness limit assertion macros
// shared assertion shorthands for the checker
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_BRIGHTNESS_LIMIT_MACROS_SVH
`define HSV_TO_RGB_BRIGHTNESS_LIMIT_MACROS_SVH

// implication checked on every rising edge outside reset
`define HRBL_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition that must never hold outside reset
`define HRBL_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

/* hw/rtl/hrbl_pkg.sv */
// ---------------------------------------------------------------------------
// hrbl_pkg
// types, constants and arithmetic helpers of the hsv to rgb limiter
// ---------------------------------------------------------------------------
package hrbl_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned SUM_W     = 10;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned PROD_W    = CHAN_W + PCT_W;
   localparam int unsigned LATENCY   = 6;

   localparam logic [SUM_W-1:0] LOW_SUM   = 10'd250;
   localparam logic [SUM_W-1:0] MID_SUM   = 10'd550;
   localparam logic [PCT_W-1:0] FULL_PCT  = 7'd100;
   localparam logic [PCT_W-1:0] HIGH_BASE = 7'd50;
   localparam logic [6:0]       HUE_SIXTH = 7'd85;

   typedef struct packed {
      logic [CHAN_W-1:0] hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness_value;
   } hrbl_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } hrbl_rsp_type;

   // floor(hue * 6 / 255), region 6 only for hue 255
   function automatic logic [2:0] hue_region(input logic [CHAN_W-1:0] hue);
      logic [10:0] x;
      logic [11:0] y;
      x = 11'(hue) * 11'd6;
      y = 12'(x) + 12'(x[10:8]) + 12'd1;
      return y[10:8];
   endfunction

   // limiter percentage from the channel sum
   function automatic logic [PCT_W-1:0] limit_pct(input logic [SUM_W-1:0] sum);
      logic [8:0]  d_low;
      logic [15:0] q_low;
      logic [7:0]  d_high;
      logic [10:0] y_high;
      logic [20:0] q_high;
      d_low  = 9'(sum - LOW_SUM);
      // d / 5 by reciprocal, exact for d up to 300
      q_low  = 16'(d_low) * 16'd205;
      d_high = 8'(sum - MID_SUM);
      // 30 d / 215 = 6 d / 43, reciprocal exact for 6 d up to 1290
      y_high = 11'(d_high) * 11'd6;
      q_high = 21'(y_high) * 21'd1525;
      if (sum < LOW_SUM) begin
         return FULL_PCT;
      end else if (sum <= MID_SUM) begin
         return FULL_PCT - PCT_W'(q_low[15:10]);
      end else begin
         return HIGH_BASE - PCT_W'(q_high[20:16]);
      end
   endfunction

   // floor(x / 100) by reciprocal, exact for x up to 25500
   function automatic logic [CHAN_W-1:0] div100(input logic [PROD_W-1:0] x);
      logic [27:0] m;
      m = 28'(x) * 28'd5243;
      return m[26:19];
   endfunction

endpackage

/* hw/rtl/hsv_to_rgb_brightness_limit.sv */
// ---------------------------------------------------------------------------
// hsv_to_rgb_brightness_limit
// 8-bit hsv to rgb conversion followed by a brightness limiter
// ---------------------------------------------------------------------------
// Takes one colour per clock: an item is accepted whenever start is high,
// since busy is never raised. Each result appears on rsp_data with
// rsp_strobe high for one cycle, in order, after its item was accepted and
// has passed the six register stages of the datapath: three for the hsv
// conversion (region, partial products, channel levels) and three for the
// limiter (percentage, scaling, divide by 100).
// The receiver must take every result in the cycle it is shown; there is no
// backpressure. Reset clears only the stage valid bits.
module hsv_to_rgb_brightness_limit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  hrbl_pkg::hrbl_req_type req_data,
   output logic                   rsp_strobe,
   output hrbl_pkg::hrbl_rsp_type rsp_data
);
   import hrbl_pkg::*;

   logic         conv_valid;
   hrbl_rsp_type conv_data;

   // pipeline never stalls
   assign busy = 1'b0;

   hrbl_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (conv_valid),
      .out_data  (conv_data)
   );

   hrbl_limit u_limit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_data   (conv_data),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule

/* hw/rtl/hrbl_convert.sv */
// ---------------------------------------------------------------------------
// hrbl_convert
// three-stage hsv to rgb conversion: region, partial products, channel levels
// ---------------------------------------------------------------------------
module hrbl_convert (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  hrbl_pkg::hrbl_req_type in_data,
   output logic                  out_valid,
   output hrbl_pkg::hrbl_rsp_type out_data
);
   import hrbl_pkg::*;

   // stage 1 registers
   logic              v1_ff;
   logic [2:0]        region1_ff, region1_in;
   logic [7:0]        rem1_ff, rem1_in;
   logic [7:0]        sat1_ff, val1_ff;

   // stage 2 registers
   logic              v2_ff;
   logic [2:0]        region2_ff;
   logic [7:0]        val2_ff;
   logic              grey2_ff;
   logic [7:0]        p2_ff, sr2_ff, srn2_ff;
   logic [15:0]       p_prod, sr_prod, srn_prod;

   // stage 3 registers
   logic              v3_ff;
   hrbl_rsp_type      rgb3_ff, rgb3_in;
   logic [15:0]       q_prod, t_prod;
   logic [7:0]        q_lvl, t_lvl;

   logic [9:0]        rem_diff;
   logic [9:0]        rem_x3;

   // hue region and in-region remainder
   always_comb begin
      region1_in = hue_region(in_data.hue);
      rem_diff   = {1'b0, in_data.hue, 1'b0} - 10'(region1_in) * 10'(HUE_SIXTH);
      rem_x3     = rem_diff + {rem_diff[8:0], 1'b0};
      rem1_in    = rem_x3[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      region1_ff <= region1_in;
      rem1_ff    <= rem1_in;
      sat1_ff    <= in_data.saturation;
      val1_ff    <= in_data.brightness_value;
   end

   // p level and scaled saturation terms
   always_comb begin
      p_prod   = 16'(val1_ff) * 16'(8'd255 - sat1_ff);
      sr_prod  = 16'(sat1_ff) * 16'(rem1_ff);
      srn_prod = 16'(sat1_ff) * 16'(8'd255 - rem1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      region2_ff <= region1_ff;
      val2_ff    <= val1_ff;
      grey2_ff   <= (sat1_ff == 8'd0);
      p2_ff      <= p_prod[15:8];
      sr2_ff     <= sr_prod[15:8];
      srn2_ff    <= srn_prod[15:8];
   end

   // q and t levels, then channel assignment per region
   always_comb begin
      q_prod = 16'(val2_ff) * 16'(8'd255 - sr2_ff);
      t_prod = 16'(val2_ff) * 16'(8'd255 - srn2_ff);
      q_lvl  = q_prod[15:8];
      t_lvl  = t_prod[15:8];
      if (grey2_ff) begin
         rgb3_in = '{red: val2_ff, green: val2_ff, blue: val2_ff};
      end else begin
         case (region2_ff)
            3'd1:    rgb3_in = '{red: q_lvl,   green: val2_ff, blue: p2_ff};
            3'd2:    rgb3_in = '{red: p2_ff,   green: val2_ff, blue: t_lvl};
            3'd3:    rgb3_in = '{red: p2_ff,   green: q_lvl,   blue: val2_ff};
            3'd4:    rgb3_in = '{red: t_lvl,   green: p2_ff,   blue: val2_ff};
            3'd5:    rgb3_in = '{red: val2_ff, green: p2_ff,   blue: q_lvl};
            default: rgb3_in = '{red: val2_ff, green: t_lvl,   blue: p2_ff};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      rgb3_ff <= rgb3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = rgb3_ff;

endmodule

/* hw/rtl/hrbl_limit.sv */
// ---------------------------------------------------------------------------
// hrbl_limit
// three-stage brightness limiter: percentage, scale, divide by 100
// ---------------------------------------------------------------------------
module hrbl_limit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  hrbl_pkg::hrbl_rsp_type in_data,
   output logic                   out_valid,
   output hrbl_pkg::hrbl_rsp_type out_data
);
   import hrbl_pkg::*;

   logic [SUM_W-1:0]  sum;
   logic              v4_ff, v5_ff, v6_ff;
   logic [PCT_W-1:0]  pct4_ff;
   hrbl_rsp_type      rgb4_ff;
   logic [PROD_W-1:0] pr5_ff, pg5_ff, pb5_ff;
   hrbl_rsp_type      rgb6_ff, rgb6_in;

   // channel sum and limiter percentage
   assign sum = SUM_W'(in_data.red) + SUM_W'(in_data.green) + SUM_W'(in_data.blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
      end
      pct4_ff <= limit_pct(sum);
      rgb4_ff <= in_data;
   end

   // scale each channel by the percentage
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      pr5_ff <= PROD_W'(rgb4_ff.red)   * PROD_W'(pct4_ff);
      pg5_ff <= PROD_W'(rgb4_ff.green) * PROD_W'(pct4_ff);
      pb5_ff <= PROD_W'(rgb4_ff.blue)  * PROD_W'(pct4_ff);
   end

   // divide by 100
   always_comb begin
      rgb6_in.red   = div100(pr5_ff);
      rgb6_in.green = div100(pg5_ff);
      rgb6_in.blue  = div100(pb5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      rgb6_ff <= rgb6_in;
   end

   assign out_valid = v6_ff;
   assign out_data  = rgb6_ff;

endmodule

/* hw/rtl/hrbl_checker.sv */
// ---------------------------------------------------------------------------
// hrbl_checker
// port-level checks of the hsv to rgb limiter, bound to the top level
// ---------------------------------------------------------------------------
`include "hsv_to_rgb_brightness_limit_macros.svh"

module hrbl_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  hrbl_pkg::hrbl_req_type req_data,
   input  logic                   rsp_strobe,
   input  hrbl_pkg::hrbl_rsp_type rsp_data
);
   import hrbl_pkg::*;

   // block never refuses an item
   `HRBL_ASSERT_NEVER(a_never_busy, busy, "busy raised")

   // every result comes from an accepted item
   `HRBL_ASSERT_IMPLY(a_result_has_item, rsp_strobe, $past(start && !busy, LATENCY), "result without item")

   // zero saturation stays grey through the limiter
   `HRBL_ASSERT_IMPLY(a_grey_kept, rsp_strobe && $past(req_data.saturation == 8'd0, LATENCY), (rsp_data.red == rsp_data.green) && (rsp_data.green == rsp_data.blue), "grey item gave colour")

   // zero value gives black
   `HRBL_ASSERT_IMPLY(a_black_kept, rsp_strobe && $past(req_data.brightness_value == 8'd0, LATENCY), (rsp_data.red == 8'd0) && (rsp_data.green == 8'd0) && (rsp_data.blue == 8'd0), "black item gave light")

endmodule

bind hsv_to_rgb_brightness_limit hrbl_checker u_hrbl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
